@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define TCF_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tcf assertion failed");

// overlapping implication check
`define TCF_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcf implication failed");

// next-cycle implication check
`define TCF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcf next-cycle check failed");

`endif

@@ design/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcf_pkg
// types and character codes of the text stream cat formatter
// ----------------------------------------------------------------------------
package tcf_pkg;

    // formatting modes, codes 9 to 15 behave as copy
    typedef enum logic [3:0] {
        MODE_COPY     = 4'd0,
        MODE_NUM_NB   = 4'd1,
        MODE_NUM_ALL  = 4'd2,
        MODE_SQUEEZE  = 4'd3,
        MODE_ENDS     = 4'd4,
        MODE_TABS     = 4'd5,
        MODE_V        = 4'd6,
        MODE_E        = 4'd7,
        MODE_T        = 4'd8
    } mode_t;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_word_t;

    // line counter holds six bcd digits
    localparam int BCD_DIGITS = 6;

    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_DOLLAR = 8'd36;
    localparam logic [7:0] CHAR_QMARK  = 8'd63;
    localparam logic [7:0] CHAR_CARET  = 8'd94;
    localparam logic [7:0] CHAR_UPPER_I = 8'd73;
    localparam logic [7:0] CHAR_DEL    = 8'd127;
    localparam logic [7:0] CARET_OFFSET = 8'd64;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

endpackage

@@ design/text_stream_cat_formatter.sv @@
// ----------------------------------------------------------------------------
// text_stream_cat_formatter
// byte stream filter with line numbering, blank-line squeeze and caret display
// ----------------------------------------------------------------------------
// Each accepted input word is formatted into a result buffer, which then
// sends one byte per cycle on the result channel while m_ready is high,
// starting the cycle after the word is taken. Most input bytes make one
// result byte, so input is taken every cycle while the output keeps up; an
// input byte that makes k result bytes holds off the input until its last
// byte leaves (caret, '$' and ^I forms make two bytes, the start of a
// numbered line makes NUMBER_DIGITS + 2). A squeezed byte makes no result.
// The next word is taken in the same cycle the last byte of the buffer leaves.
// The user must write the mode register through the cfg port only while
// the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_stream_cat_formatter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_mode,
    // input stream
    input  logic                s_valid,
    output logic                s_ready,
    input  tcf_pkg::in_word_t   s_data,
    // result stream
    output logic                m_valid,
    input  logic                m_ready,
    output tcf_pkg::out_word_t  m_data
);

    localparam int MAX_RES = NUMBER_DIGITS + 2;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int USED    = (NUMBER_DIGITS < tcf_pkg::BCD_DIGITS) ?
                             NUMBER_DIGITS : tcf_pkg::BCD_DIGITS;
    localparam int DISP_W  = (NUMBER_DIGITS > tcf_pkg::BCD_DIGITS) ?
                             NUMBER_DIGITS : tcf_pkg::BCD_DIGITS;
    localparam int BCD_W   = 4 * tcf_pkg::BCD_DIGITS;

    tcf_pkg::mode_t     mode_reg;
    logic [BCD_W-1:0]   count_reg, count_next;
    logic               at_start_reg, at_start_next;
    logic [1:0]         newline_run_reg, newline_run_next;
    logic [7:0]         slot_reg [MAX_RES];
    logic [CNT_W-1:0]   remain_reg;

    logic               in_fire, out_fire;
    logic [7:0]         in_byte;
    logic               is_nl, is_tab, is_ctrl;
    logic [BCD_W-1:0]   cur_count, inc_count;
    logic               cur_start;
    logic [1:0]         cur_run;
    logic               put_num;
    logic [7:0]         tail0, tail1;
    logic [1:0]         tail_cnt;
    logic [7:0]         new_slot [MAX_RES];
    logic [CNT_W-1:0]   new_cnt;
    logic [7:0]         num_char [NUMBER_DIGITS];

    assign cfg_ready = 1'b1;
    assign m_valid   = (remain_reg != '0);
    assign out_fire  = m_valid && m_ready;
    assign s_ready   = (remain_reg == '0) ||
                       ((remain_reg == CNT_W'(1)) && m_ready);
    assign in_fire   = s_valid && s_ready;

    assign m_data.out_byte = slot_reg[0];
    assign m_data.last     = (remain_reg == CNT_W'(1));

    // per-file state seen by this word
    assign in_byte   = s_data.data_byte;
    assign cur_count = s_data.file_start ? '0 : count_reg;
    assign cur_start = s_data.file_start ? 1'b1 : at_start_reg;
    assign cur_run   = s_data.file_start ? 2'd1 : newline_run_reg;

    assign is_nl   = (in_byte == tcf_pkg::CHAR_NL);
    assign is_tab  = (in_byte == tcf_pkg::CHAR_TAB);
    assign is_ctrl = ((in_byte < tcf_pkg::CHAR_SPACE) && !is_tab && !is_nl &&
                      (in_byte != tcf_pkg::CHAR_CR)) ||
                     (in_byte == tcf_pkg::CHAR_DEL);

    // newline run counter, saturating at three
    always_comb begin
        if (!is_nl) begin
            newline_run_next = 2'd0;
        end else if (cur_run != 2'd3) begin
            newline_run_next = cur_run + 2'd1;
        end else begin
            newline_run_next = cur_run;
        end
    end
    assign at_start_next = is_nl;

    // bcd increment over the used digits, holding at all nines
    always_comb begin
        logic all_nine;
        logic carry;
        all_nine  = 1'b1;
        carry     = 1'b1;
        inc_count = cur_count;
        for (int i = 0; i < USED; i++) begin
            if (cur_count[4*i +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        for (int i = 0; i < USED; i++) begin
            if (carry) begin
                if (cur_count[4*i +: 4] >= 4'd9) begin
                    inc_count[4*i +: 4] = 4'd0;
                end else begin
                    inc_count[4*i +: 4] = cur_count[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine) begin
            inc_count = cur_count;
        end
    end

    // right-aligned decimal with leading spaces
    always_comb begin
        logic [4*DISP_W-1:0] wide;
        logic                leading;
        logic [3:0]          d;
        wide         = '0;
        wide[BCD_W-1:0] = inc_count;
        leading      = 1'b1;
        for (int pos = NUMBER_DIGITS - 1; pos >= 0; pos--) begin
            d = wide[4*pos +: 4];
            if ((d != 4'd0) || (pos == 0)) begin
                leading = 1'b0;
            end
            num_char[NUMBER_DIGITS-1-pos] = leading ? tcf_pkg::CHAR_SPACE :
                                            {tcf_pkg::ASCII_DIGIT_HI, d};
        end
    end

    // mode decode: number prefix or up to two bytes of plain output
    always_comb begin
        put_num  = 1'b0;
        tail0    = in_byte;
        tail1    = in_byte;
        tail_cnt = 2'd1;
        unique case (mode_reg)
            tcf_pkg::MODE_NUM_NB: begin
                put_num = cur_start && !is_nl;
            end
            tcf_pkg::MODE_NUM_ALL: begin
                put_num = cur_start;
            end
            tcf_pkg::MODE_SQUEEZE: begin
                tail_cnt = (newline_run_next == 2'd3) ? 2'd0 : 2'd1;
            end
            tcf_pkg::MODE_ENDS: begin
                if (is_nl) begin
                    tail0    = tcf_pkg::CHAR_DOLLAR;
                    tail_cnt = 2'd2;
                end
            end
            tcf_pkg::MODE_TABS: begin
                if (is_tab) begin
                    tail0    = tcf_pkg::CHAR_CARET;
                    tail1    = tcf_pkg::CHAR_UPPER_I;
                    tail_cnt = 2'd2;
                end
            end
            tcf_pkg::MODE_V, tcf_pkg::MODE_E, tcf_pkg::MODE_T: begin
                if ((mode_reg == tcf_pkg::MODE_E) && is_nl) begin
                    tail0    = tcf_pkg::CHAR_DOLLAR;
                    tail_cnt = 2'd2;
                end else if ((mode_reg == tcf_pkg::MODE_T) && is_tab) begin
                    tail0    = tcf_pkg::CHAR_CARET;
                    tail1    = tcf_pkg::CHAR_UPPER_I;
                    tail_cnt = 2'd2;
                end else if (is_ctrl) begin
                    tail0    = tcf_pkg::CHAR_CARET;
                    tail1    = (in_byte == tcf_pkg::CHAR_DEL) ? tcf_pkg::CHAR_QMARK :
                               (in_byte | tcf_pkg::CARET_OFFSET);
                    tail_cnt = 2'd2;
                end
            end
            default: begin
            end
        endcase
    end

    // result bytes of this word
    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            new_slot[i] = in_byte;
        end
        if (put_num) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                new_slot[i] = num_char[i];
            end
            new_slot[NUMBER_DIGITS]     = tcf_pkg::CHAR_TAB;
            new_slot[NUMBER_DIGITS + 1] = in_byte;
            new_cnt = CNT_W'(MAX_RES);
        end else begin
            new_slot[0] = tail0;
            new_slot[1] = tail1;
            new_cnt     = CNT_W'(tail_cnt);
        end
    end

    assign count_next = put_num ? inc_count : cur_count;

    // mode register and per-file state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= tcf_pkg::MODE_COPY;
            count_reg       <= '0;
            at_start_reg    <= 1'b1;
            newline_run_reg <= 2'd1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= tcf_pkg::mode_t'(cfg_mode);
            end
            if (in_fire) begin
                count_reg       <= count_next;
                at_start_reg    <= at_start_next;
                newline_run_reg <= newline_run_next;
            end
        end
    end

    // result buffer fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else if (in_fire) begin
            remain_reg <= new_cnt;
        end else if (out_fire) begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    // result buffer bytes, shifted toward slot zero as bytes leave
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < MAX_RES; i++) begin
                slot_reg[i] <= new_slot[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

    // checks
    `TCF_ASSERT_IMPL(a_stall_only_when_busy, aclk, aresetn, !s_ready, m_valid)
    `TCF_ASSERT(a_start_matches_run, aclk, aresetn,
        at_start_reg == (newline_run_reg != 2'd0))
    `TCF_ASSERT_NEXT(a_nl_sets_start, aclk, aresetn,
        in_fire && (s_data.data_byte == tcf_pkg::CHAR_NL), at_start_reg)
    `TCF_ASSERT_NEXT(a_drain_when_idle, aclk, aresetn,
        out_fire && m_data.last && !in_fire, !m_valid)

endmodule
